[rtl/smp_pkg.sv]
// Shared types and constants for the SHA-256 message padder.
package smp_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WIB_W       = 4;
    localparam int unsigned POS_W       = 2;
    localparam int unsigned LEN_FULL_W  = 64;

    localparam logic [BYTE_W-1:0] MARKER_BYTE   = 8'h80;
    localparam logic [WIB_W-1:0]  LENGTH_SLOT   = 4'd14;
    localparam logic [WIB_W-1:0]  LAST_SLOT     = 4'd15;
    localparam logic [POS_W-1:0]  LAST_BYTE_POS = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] message_byte;
        logic              byte_present;
        logic              end_of_message;
    } smp_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] padded_word;
        logic              end_of_block;
        logic              last_word;
    } smp_out_t;

    typedef struct packed {
        logic              load;
        logic              clear_word;
        logic              clear_all;
        logic [BYTE_W-1:0] data;
    } smp_pack_cmd_t;

    function automatic logic [WORD_W-1:0] place_byte(
        input logic [BYTE_W-1:0] b,
        input logic [POS_W-1:0]  pos
    );
        logic [WORD_W-1:0] w;
        begin
            w = '0;
            case (pos)
                2'd0:    w[31:24] = b;
                2'd1:    w[23:16] = b;
                2'd2:    w[15:8]  = b;
                default: w[7:0]   = b;
            endcase
            return w;
        end
    endfunction

endpackage

[rtl/sha256_message_padder.sv]
// SHA-256 message padder top level: padding sequencer and output register.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+----------------------------
//  msg     | msg_valid  | msg_ready  | msg  (smp_pkg::smp_in_t)
//  word    | word_valid | word_ready | word (smp_pkg::smp_out_t)
//
// A request with no completed word or end mark is taken in S_IDLE; one
// completing a word also passes S_DATA. An end mark steps through marker,
// zero fill and two length words, one word per cycle while not stalled.
// Reset clears all state; msg_ready is low while the sequencer emits.
// A stalled word_ready holds the sequencer on its current word.
module sha256_message_padder #(
    parameter int unsigned LENGTH_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  smp_pkg::smp_in_t  msg,
    output logic              word_valid,
    input  logic              word_ready,
    output smp_pkg::smp_out_t word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DATA,
        S_MARK,
        S_ZERO,
        S_LENHI,
        S_LENLO
    } state_t;

    state_t                         state_reg, state_next;
    logic                           finish_reg, finish_next;
    logic [smp_pkg::WIB_W-1:0]      wib_reg, wib_next;
    smp_pkg::smp_out_t              word_reg, word_next;
    logic                           word_valid_reg, word_valid_next;

    smp_pkg::smp_pack_cmd_t         cmd;
    logic [smp_pkg::WORD_W-1:0]     partial_word;
    logic [smp_pkg::POS_W-1:0]      byte_position;
    logic [LENGTH_WIDTH-1:0]        bit_length;
    logic [smp_pkg::LEN_FULL_W-1:0] len_full;
    logic                           slot_free;
    logic                           emit;
    logic                           accept;

    smp_packer #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .partial_word  (partial_word),
        .byte_position (byte_position),
        .bit_length    (bit_length)
    );

    assign len_full  = smp_pkg::LEN_FULL_W'(bit_length);
    assign slot_free = !word_valid_reg || word_ready;
    assign accept    = msg_valid && msg_ready;

    always_comb
    begin
        state_next      = state_reg;
        finish_next     = finish_reg;
        wib_next        = wib_reg;
        word_next       = word_reg;
        emit            = 1'b0;
        cmd.load        = 1'b0;
        cmd.clear_word  = 1'b0;
        cmd.clear_all   = 1'b0;
        cmd.data        = msg.message_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    finish_next = msg.end_of_message;
                    cmd.load    = msg.byte_present;
                    if (msg.byte_present && byte_position == smp_pkg::LAST_BYTE_POS)
                        state_next = S_DATA;
                    else if (msg.end_of_message)
                        state_next = S_MARK;
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    word_next.padded_word = partial_word;
                    word_next.last_word   = 1'b0;
                    cmd.clear_word        = 1'b1;
                    state_next            = finish_reg ? S_MARK : S_IDLE;
                end
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    word_next.padded_word = partial_word
                        | smp_pkg::place_byte(smp_pkg::MARKER_BYTE, byte_position);
                    word_next.last_word   = 1'b0;
                    state_next = (wib_reg + smp_pkg::WIB_W'(1) == smp_pkg::LENGTH_SLOT)
                                 ? S_LENHI : S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    word_next.padded_word = '0;
                    word_next.last_word   = 1'b0;
                    if (wib_reg + smp_pkg::WIB_W'(1) == smp_pkg::LENGTH_SLOT)
                        state_next = S_LENHI;
                end
            end
            S_LENHI:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    word_next.padded_word = len_full[63:32];
                    word_next.last_word   = 1'b0;
                    state_next            = S_LENLO;
                end
            end
            S_LENLO:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    word_next.padded_word = len_full[31:0];
                    word_next.last_word   = 1'b1;
                    cmd.clear_all         = 1'b1;
                    finish_next           = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            word_next.end_of_block = (wib_reg == smp_pkg::LAST_SLOT);
            wib_next               = (state_reg == S_LENLO) ? '0
                                     : wib_reg + smp_pkg::WIB_W'(1);
            word_valid_next        = 1'b1;
        end
        else if (word_ready)
            word_valid_next = 1'b0;
        else
            word_valid_next = word_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            finish_reg     <= 1'b0;
            wib_reg        <= '0;
            word_valid_reg <= 1'b0;
            word_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            finish_reg     <= finish_next;
            wib_reg        <= wib_next;
            word_valid_reg <= word_valid_next;
            word_reg       <= word_next;
        end
    end

    assign msg_ready  = (state_reg == S_IDLE);
    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule

[rtl/smp_packer.sv]
// Byte packer: partial word, byte position and running bit length.
module smp_packer #(
    parameter int unsigned LENGTH_WIDTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  smp_pkg::smp_pack_cmd_t           cmd,
    output logic [smp_pkg::WORD_W-1:0]       partial_word,
    output logic [smp_pkg::POS_W-1:0]        byte_position,
    output logic [LENGTH_WIDTH-1:0]          bit_length
);

    logic [smp_pkg::WORD_W-1:0] partial_reg, partial_next;
    logic [smp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [LENGTH_WIDTH-1:0]    len_reg, len_next;

    always_comb
    begin
        partial_next = partial_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        if (cmd.clear_all)
        begin
            partial_next = '0;
            pos_next     = '0;
            len_next     = '0;
        end
        else if (cmd.clear_word)
        begin
            partial_next = '0;
        end
        else if (cmd.load)
        begin
            partial_next = partial_reg | smp_pkg::place_byte(cmd.data, pos_reg);
            pos_next     = pos_reg + smp_pkg::POS_W'(1);
            len_next     = len_reg + LENGTH_WIDTH'(smp_pkg::BYTE_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
        end
    end

    assign partial_word  = partial_reg;
    assign byte_position = pos_reg;
    assign bit_length    = len_reg;

endmodule
